// ----- hdl/pssw_pkg.sv -----
package pssw_pkg;

    // Palette store geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

    // Fixed words of the span format
    localparam logic [31:0] SIGNATURE_WORD  = 32'h006d_6647;
    localparam logic [31:0] TERMINATOR_WORD = 32'h2a2a_2a2a;

    // Header is 16 bytes, the last one at offset 15
    localparam logic [10:0] HDR_LAST = 11'd15;

    // Parser phases
    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_PALETTE = 6'b000010,
        PH_COUNT   = 6'b000100,
        PH_JUMP    = 6'b001000,
        PH_SIZE    = 6'b010000,
        PH_PIXELS  = 6'b100000
    } t_phase;

    // One output beat
    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        bad;
    } t_beat;

    // Words one input byte produces; slots 0 and 1 may take palette read data
    typedef struct packed {
        t_beat [3:0] slots;
        logic  [2:0] cnt;
        logic  [1:0] mem;
    } t_job;

endpackage

// ----- hdl/packed_sprite_to_span_words_top.sv -----
// Packed sprite to span words: takes a packed sprite object one byte per beat
// and returns the unpacked span format as 32-bit words, one word per beat.
// The 16-byte header and palette bytes give no words until the last one,
// which gives the signature, object size and packed width/height words (plus
// the terminator for a zero-height sprite). Count, jump and size bytes give
// one word each, a pixel byte one or two palette words; the byte that ends
// the object adds the terminator, which carries tlast. A pixel index not
// below the palette count gives a zero word with tuser set. Palette entries
// live in a 256 x 24 memory with one write port and two registered read
// ports, read in the cycle a pixel byte is taken, so both nibbles are looked
// up at once. Words wait in stage 1 for read data, then in the output stage.
// The output side sets the rate: one input byte per cycle, while the output
// is ready, for bytes that give one word or none; others hold the input back.
module packed_sprite_to_span_words_top
    import pssw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] out_word
    output logic        o_m_axis_tlast,   // is_last
    output logic        o_m_axis_tuser    // [0] bad_index
);

    // Parser state
    t_phase      r_phase,    n_phase;
    logic [10:0] r_byte_cnt, n_byte_cnt;
    logic [7:0]  r_pal_cnt,  n_pal_cnt;
    logic [15:0] r_width,    n_width;
    logic [15:0] r_height,   n_height;
    logic [31:0] r_obj_size, n_obj_size;
    logic [15:0] r_lines,    n_lines;
    logic [7:0]  r_spans,    n_spans;
    logic [7:0]  r_pixels,   n_pixels;
    logic [15:0] r_ent,      n_ent;

    // Palette memory
    logic [23:0]       r_pal [PALETTE_DEPTH];
    logic [23:0]       r_rd0, r_rd1;
    logic              pal_we;
    logic [7:0]        pal_slot;
    logic [23:0]       pal_wdata;
    logic [7:0]        rd_idx0, rd_idx1;

    // Pipeline
    t_job        job;
    t_job        r_s1;
    logic        r_s1_vld;
    t_beat [3:0] r_ob;
    logic  [2:0] r_ocnt;
    t_beat [3:0] load_beats;

    logic in_fire, out_fire, out_free, s1_adv;

    assign in_fire  = i_s_axis_tvalid & o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid & i_m_axis_tready;
    assign out_free = (r_ocnt == 3'd0) || ((r_ocnt == 3'd1) && out_fire);
    assign s1_adv   = r_s1_vld & out_free;

    assign o_s_axis_tready = !r_s1_vld || out_free;
    assign o_m_axis_tvalid = (r_ocnt != 3'd0);
    assign o_m_axis_tdata  = r_ob[0].word;
    assign o_m_axis_tlast  = r_ob[0].last;
    assign o_m_axis_tuser  = r_ob[0].bad;

    // Byte parser: next state and the words this byte produces
    always_comb begin
        logic [7:0]  b;
        logic        end_span, end_line, start_body, finish;
        logic [2:0]  nb;
        logic        good0, good1;
        logic [7:0]  spans_dec;
        logic [15:0] lines_dec;
        logic [10:0] pal_bytes;
        t_beat       term;

        b          = i_s_axis_tdata;
        end_span   = 1'b0;
        end_line   = 1'b0;
        start_body = 1'b0;
        finish     = 1'b0;
        nb         = 3'd0;
        spans_dec  = r_spans - 8'd1;
        lines_dec  = r_lines - 16'd1;
        pal_bytes  = {1'b0, r_pal_cnt, 2'b00};
        term       = '{word: TERMINATOR_WORD, last: 1'b1, bad: 1'b0};

        n_phase    = r_phase;
        n_byte_cnt = r_byte_cnt;
        n_pal_cnt  = r_pal_cnt;
        n_width    = r_width;
        n_height   = r_height;
        n_obj_size = r_obj_size;
        n_lines    = r_lines;
        n_spans    = r_spans;
        n_pixels   = r_pixels;
        n_ent      = r_ent;
        job        = '0;
        pal_we     = 1'b0;
        pal_slot   = r_byte_cnt[9:2];
        pal_wdata  = {b, r_ent};

        // Read addresses for pixel lookups
        rd_idx0 = (r_pixels > 8'd1) ? {4'h0, b[7:4]} : b;
        rd_idx1 = {4'h0, b[3:0]};
        good0   = (rd_idx0 < r_pal_cnt) && ({1'b0, rd_idx0} < 9'(PALETTE_DEPTH));
        good1   = (rd_idx1 < r_pal_cnt) && ({1'b0, rd_idx1} < 9'(PALETTE_DEPTH));

        unique case (r_phase)
            PH_HEADER: begin
                case (r_byte_cnt[3:0])
                    4'd3:  n_pal_cnt = b;
                    4'd8:  n_width = {8'h00, b};
                    4'd9:  n_width = {b, r_width[7:0]};
                    4'd10: n_height = {8'h00, b};
                    4'd11: n_height = {b, r_height[7:0]};
                    4'd12: n_obj_size = {24'h0, b};
                    4'd13: n_obj_size = {16'h0, b, r_obj_size[7:0]};
                    4'd14: n_obj_size = {8'h0, b, r_obj_size[15:0]};
                    4'd15: n_obj_size = {b, r_obj_size[23:0]};
                    default: ;
                endcase
                if (r_byte_cnt >= HDR_LAST) begin
                    n_byte_cnt = 11'd0;
                    n_ent      = 16'd0;
                    if (n_pal_cnt == 8'd0) begin
                        start_body = 1'b1;
                    end else begin
                        n_phase = PH_PALETTE;
                    end
                end else begin
                    n_byte_cnt = r_byte_cnt + 11'd1;
                end
            end
            PH_PALETTE: begin
                // Entry bytes 1, 2 and 3 are kept; byte 0 is dropped
                case (r_byte_cnt[1:0])
                    2'd1: n_ent[7:0]  = b;
                    2'd2: n_ent[15:8] = b;
                    2'd3: begin
                        pal_we = ({1'b0, pal_slot} < 9'(PALETTE_DEPTH));
                        n_ent  = 16'd0;
                    end
                    default: ;
                endcase
                n_byte_cnt = r_byte_cnt + 11'd1;
                if (n_byte_cnt >= pal_bytes) begin
                    n_byte_cnt = 11'd0;
                    start_body = 1'b1;
                end
            end
            PH_COUNT: begin
                job.slots[0] = '{word: {24'h0, b}, last: 1'b0, bad: 1'b0};
                nb = 3'd1;
                if (b == 8'd0) begin
                    end_line = 1'b1;
                end else begin
                    n_spans = b;
                    n_phase = PH_JUMP;
                end
            end
            PH_JUMP: begin
                job.slots[0] = '{word: {24'h0, b}, last: 1'b0, bad: 1'b0};
                nb = 3'd1;
                n_phase = PH_SIZE;
            end
            PH_SIZE: begin
                job.slots[0] = '{word: {24'h0, b}, last: 1'b0, bad: 1'b0};
                nb = 3'd1;
                if (b == 8'd0) begin
                    end_span = 1'b1;
                end else begin
                    n_pixels = b;
                    n_phase  = PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                // Bad indices give a zero word; good ones take read data
                job.slots[0] = '{word: 32'h0, last: 1'b0, bad: !good0};
                job.mem[0]   = good0;
                if (r_pixels > 8'd1) begin
                    job.slots[1] = '{word: 32'h0, last: 1'b0, bad: !good1};
                    job.mem[1]   = good1;
                    nb = 3'd2;
                    n_pixels = r_pixels - 8'd2;
                end else begin
                    nb = 3'd1;
                    n_pixels = 8'd0;
                end
                if (n_pixels == 8'd0) begin
                    end_span = 1'b1;
                end
            end
            default: begin
                n_phase    = PH_HEADER;
                n_byte_cnt = 11'd0;
            end
        endcase

        // Span, line and object endings chain into each other
        if (end_span) begin
            n_spans = spans_dec;
            if (spans_dec == 8'd0) begin
                end_line = 1'b1;
            end else begin
                n_phase = PH_JUMP;
            end
        end
        if (end_line) begin
            n_lines = lines_dec;
            if (lines_dec == 16'd0) begin
                finish = 1'b1;
            end else begin
                n_phase = PH_COUNT;
            end
        end
        if (start_body) begin
            job.slots[0] = '{word: SIGNATURE_WORD, last: 1'b0, bad: 1'b0};
            job.slots[1] = '{word: n_obj_size, last: 1'b0, bad: 1'b0};
            job.slots[2] = '{word: {n_width, n_height}, last: 1'b0, bad: 1'b0};
            nb = 3'd3;
            n_lines = n_height;
            if (n_height == 16'd0) begin
                finish = 1'b1;
            end else begin
                n_phase = PH_COUNT;
            end
        end
        if (finish) begin
            case (nb)
                3'd0:    job.slots[0] = term;
                3'd1:    job.slots[1] = term;
                3'd2:    job.slots[2] = term;
                default: job.slots[3] = term;
            endcase
            nb         = nb + 3'd1;
            n_phase    = PH_HEADER;
            n_byte_cnt = 11'd0;
        end
        job.cnt = nb;
    end

    // Parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_byte_cnt <= '0;
            r_pal_cnt  <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_obj_size <= '0;
            r_lines    <= '0;
            r_spans    <= '0;
            r_pixels   <= '0;
            r_ent      <= '0;
        end else if (in_fire) begin
            r_phase    <= n_phase;
            r_byte_cnt <= n_byte_cnt;
            r_pal_cnt  <= n_pal_cnt;
            r_width    <= n_width;
            r_height   <= n_height;
            r_obj_size <= n_obj_size;
            r_lines    <= n_lines;
            r_spans    <= n_spans;
            r_pixels   <= n_pixels;
            r_ent      <= n_ent;
        end
    end

    // Palette memory: write while loading, two reads per pixel byte.
    // Read data holds until the next accepted byte.
    always_ff @(posedge i_clk) begin
        if (in_fire && pal_we) begin
            r_pal[pal_slot[PAL_AW-1:0]] <= pal_wdata;
        end
        if (in_fire) begin
            r_rd0 <= r_pal[rd_idx0[PAL_AW-1:0]];
            r_rd1 <= r_pal[rd_idx1[PAL_AW-1:0]];
        end
    end

    // Stage 1: job waits here while its read data comes back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_fire) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= job;
        end
    end

    // Merge read data into the pixel slots
    always_comb begin
        load_beats = r_s1.slots;
        if (r_s1.mem[0]) begin
            load_beats[0].word = {8'h00, r_rd0};
        end
        if (r_s1.mem[1]) begin
            load_beats[1].word = {8'h00, r_rd1};
        end
    end

    // Output stage: shift out one word per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= 3'd0;
        end else if (s1_adv) begin
            r_ocnt <= r_s1.cnt;
        end else if (out_fire) begin
            r_ocnt <= r_ocnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_ob <= load_beats;
        end else if (out_fire) begin
            r_ob[0] <= r_ob[1];
            r_ob[1] <= r_ob[2];
            r_ob[2] <= r_ob[3];
        end
    end

endmodule

// ----- hdl/pssw_checker.sv -----
module pssw_checker
    import pssw_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        o_m_axis_tuser
);

    // No words come out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // The terminator is the only word with tlast
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            (o_m_axis_tdata == TERMINATOR_WORD) && !o_m_axis_tuser)
        else $error("tlast on a word other than the terminator");

    // A bad pixel index always reads as zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
            (o_m_axis_tdata == 32'h0) && !o_m_axis_tlast)
        else $error("bad index word is not zero");

    // A stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

endmodule

bind packed_sprite_to_span_words_top pssw_checker u_pssw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ----- bench/tb_packed_sprite_to_span_words_top.sv -----
module tb_packed_sprite_to_span_words_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pssw_pkg::*;

    localparam int  RANDOM_ITEMS = 24;
    localparam int  HOLD_AFTER   = 50;       // input beats before the long output stall
    localparam int  HOLD_CYCLES  = 200;
    localparam int  DRAIN_CYCLES = 16;
    localparam time RUN_LIMIT    = 2_000_000ns;

    typedef enum int {SINK_OPEN, SINK_TOGGLE, SINK_MOSTLY, SINK_SPARSE} t_sink_mode;

    // Span word predictor: parses the byte stream and queues the words it implies
    class span_word_predictor;
        t_phase      phase;
        logic [10:0] byte_count;
        logic [7:0]  pal_count;
        logic [15:0] sprite_w;
        logic [15:0] sprite_h;
        logic [31:0] obj_size;
        logic [15:0] lines_left;
        logic [7:0]  spans_left;
        logic [7:0]  pixels_left;
        logic [31:0] entry;
        logic [23:0] pal_store [PALETTE_DEPTH];
        t_beat       pending_words [$];
        int          errors;
        int          bytes_in;

        function new();
            phase       = PH_HEADER;
            byte_count  = '0;
            pal_count   = '0;
            sprite_w    = '0;
            sprite_h    = '0;
            obj_size    = '0;
            lines_left  = '0;
            spans_left  = '0;
            pixels_left = '0;
            entry       = '0;
            errors      = 0;
            bytes_in    = 0;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void push_word(logic [31:0] w, logic lst, logic bd);
            t_beat e;
            e.word = w;
            e.last = lst;
            e.bad  = bd;
            pending_words.push_back(e);
        endfunction

        // indices past the loaded palette give a zero word flagged bad
        function void push_pixel(logic [7:0] idx);
            if (idx < pal_count && int'(idx) < PALETTE_DEPTH) begin
                push_word({8'd0, pal_store[idx]}, 1'b0, 1'b0);
            end else begin
                push_word(32'd0, 1'b0, 1'b1);
            end
        endfunction

        function void finish_object();
            push_word(TERMINATOR_WORD, 1'b1, 1'b0);
            phase      = PH_HEADER;
            byte_count = '0;
        endfunction

        function void end_line();
            lines_left = lines_left - 16'd1;
            if (lines_left == 16'd0) begin
                finish_object();
            end else begin
                phase = PH_COUNT;
            end
        endfunction

        function void end_span();
            spans_left = spans_left - 8'd1;
            if (spans_left == 8'd0) begin
                end_line();
            end else begin
                phase = PH_JUMP;
            end
        endfunction

        function void start_body();
            push_word(SIGNATURE_WORD, 1'b0, 1'b0);
            push_word(obj_size, 1'b0, 1'b0);
            push_word({sprite_w, sprite_h}, 1'b0, 1'b0);
            lines_left = sprite_h;
            if (lines_left == 16'd0) begin
                finish_object();
            end else begin
                phase = PH_COUNT;
            end
        endfunction

        // one accepted input beat
        function void take_byte(logic [7:0] b);
            bytes_in++;
            case (phase)
                PH_HEADER: begin
                    case (byte_count)
                        11'd3:  pal_count = b;
                        11'd8:  sprite_w = {8'd0, b};
                        11'd9:  sprite_w[15:8] = b;
                        11'd10: sprite_h = {8'd0, b};
                        11'd11: sprite_h[15:8] = b;
                        11'd12: obj_size = {24'd0, b};
                        11'd13: obj_size[15:8] = b;
                        11'd14: obj_size[23:16] = b;
                        11'd15: obj_size[31:24] = b;
                        default: ;
                    endcase
                    if (byte_count >= HDR_LAST) begin
                        byte_count = '0;
                        entry      = '0;
                        if (pal_count == 8'd0) begin
                            start_body();
                        end else begin
                            phase = PH_PALETTE;
                        end
                    end else begin
                        byte_count = byte_count + 11'd1;
                    end
                end
                PH_PALETTE: begin
                    // entries arrive little endian, only bits 31..8 are kept
                    entry[byte_count[1:0] * 8 +: 8] = b;
                    if (byte_count[1:0] == 2'd3) begin
                        if (int'(byte_count >> 2) < PALETTE_DEPTH)
                            pal_store[byte_count >> 2] = entry[31:8];
                        entry = '0;
                    end
                    byte_count = byte_count + 11'd1;
                    if (int'(byte_count) >= 4 * int'(pal_count)) begin
                        byte_count = '0;
                        start_body();
                    end
                end
                PH_COUNT: begin
                    push_word({24'd0, b}, 1'b0, 1'b0);
                    if (b == 8'd0) begin
                        end_line();
                    end else begin
                        spans_left = b;
                        phase      = PH_JUMP;
                    end
                end
                PH_JUMP: begin
                    push_word({24'd0, b}, 1'b0, 1'b0);
                    phase = PH_SIZE;
                end
                PH_SIZE: begin
                    push_word({24'd0, b}, 1'b0, 1'b0);
                    if (b == 8'd0) begin
                        end_span();
                    end else begin
                        pixels_left = b;
                        phase       = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    // high nibble first; a lone last pixel takes the whole byte
                    if (pixels_left > 8'd1) begin
                        push_pixel({4'd0, b[7:4]});
                        push_pixel({4'd0, b[3:0]});
                        pixels_left = pixels_left - 8'd2;
                    end else begin
                        push_pixel(b);
                        pixels_left = 8'd0;
                    end
                    if (pixels_left == 8'd0)
                        end_span();
                end
                default: begin
                    phase      = PH_HEADER;
                    byte_count = '0;
                end
            endcase
        endfunction

        // one accepted output beat against the oldest expected word
        function void match_word(t_beat got);
            t_beat want;
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat word %h last %b bad %b",
                         $time, got.word, got.last, got.bad);
                return;
            end
            want = pending_words.pop_front();
            if (got.word !== want.word) begin
                errors++;
                $display("%0t: word expected %h actual %h", $time, want.word, got.word);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            end
            if (got.bad !== want.bad) begin
                errors++;
                $display("%0t: bad index expected %b actual %b", $time, want.bad, got.bad);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = 8'd0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic        m_last;
    logic        m_user;

    logic [7:0]         sprite_bytes [$];
    span_word_predictor predictor;

    packed_sprite_to_span_words_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stimulus builders
    function automatic void push_header(int pal_n, logic [15:0] wid, logic [15:0] hgt,
                                        logic [31:0] osize, bit rand_pal);
        logic [7:0] hdr [16];
        for (int i = 0; i < 16; i++)
            hdr[i] = 8'($urandom);
        hdr[3]  = 8'(pal_n);
        hdr[8]  = wid[7:0];
        hdr[9]  = wid[15:8];
        hdr[10] = hgt[7:0];
        hdr[11] = hgt[15:8];
        hdr[12] = osize[7:0];
        hdr[13] = osize[15:8];
        hdr[14] = osize[23:16];
        hdr[15] = osize[31:24];
        for (int i = 0; i < 16; i++)
            sprite_bytes.push_back(hdr[i]);
        if (rand_pal) begin
            for (int i = 0; i < 4 * pal_n; i++)
                sprite_bytes.push_back(8'($urandom));
        end
    endfunction

    // mostly in-range indices, some past the palette
    function automatic int pick_index(int pal_n, int span);
        if (pal_n > 0 && $urandom_range(0, 4) != 0)
            return $urandom_range(0, ((pal_n < span) ? pal_n : span) - 1);
        return $urandom_range(0, span - 1);
    endfunction

    function automatic void add_pixels(int pal_n, int npix);
        int left;
        left = npix;
        while (left > 1) begin
            sprite_bytes.push_back({4'(pick_index(pal_n, 16)), 4'(pick_index(pal_n, 16))});
            left -= 2;
        end
        if (left == 1)
            sprite_bytes.push_back(8'(pick_index(pal_n, 256)));
    endfunction

    function automatic void add_object(int pal_n, logic [15:0] hgt, int max_spans,
                                       int max_size);
        int nspan;
        int npix;
        push_header(pal_n, 16'($urandom), hgt, 32'($urandom), 1'b1);
        for (int ln = 0; ln < int'(hgt); ln++) begin
            nspan = $urandom_range(0, max_spans);
            sprite_bytes.push_back(8'(nspan));
            for (int s = 0; s < nspan; s++) begin
                npix = $urandom_range(0, max_size);
                sprite_bytes.push_back(8'($urandom));
                sprite_bytes.push_back(8'(npix));
                add_pixels(pal_n, npix);
            end
        end
    endfunction

    function automatic void build_stimulus();
        int start;
        int pal_n;
        // no palette, zero height: header words then the terminator
        push_header(0, 16'hffff, 16'h0000, 32'hffff_ffff, 1'b0);
        // two entries, an empty line, a zero-size span with an oversized jump,
        // then pixels in range, at the count and past it
        push_header(2, 16'h0004, 16'h0002, 32'h0000_0000, 1'b0);
        sprite_bytes.push_back(8'h00); sprite_bytes.push_back(8'h11);
        sprite_bytes.push_back(8'h22); sprite_bytes.push_back(8'h33);
        sprite_bytes.push_back(8'hff); sprite_bytes.push_back(8'hff);
        sprite_bytes.push_back(8'hff); sprite_bytes.push_back(8'hff);
        sprite_bytes.push_back(8'h00);
        sprite_bytes.push_back(8'h02);
        sprite_bytes.push_back(8'hff); sprite_bytes.push_back(8'h00);
        sprite_bytes.push_back(8'h00); sprite_bytes.push_back(8'h05);
        sprite_bytes.push_back(8'h1a); sprite_bytes.push_back(8'h02);
        sprite_bytes.push_back(8'hff);

        // small random objects
        start = sprite_bytes.size();
        while (sprite_bytes.size() - start < RANDOM_ITEMS) begin
            pal_n = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 20)
                                                : $urandom_range(0, 6);
            add_object(pal_n, 16'($urandom_range(0, 3)), 3, 7);
        end
        // broken tail: a cut-off object whose height has its top bits set,
        // so the width/height word shows it as unsigned; the noise fills its palette
        push_header(3, 16'($urandom), 16'h8081, 32'($urandom), 1'b0);
        repeat (12)
            sprite_bytes.push_back(8'($urandom));
    endfunction

    // Source side: bursts of beats with random gaps
    initial begin : source
        int burst;
        int gap;
        int k;
        predictor = new();
        build_stimulus();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        k = 0;
        while (k < sprite_bytes.size()) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && k < sprite_bytes.size()) begin
                s_valid <= 1'b1;
                s_data  <= sprite_bytes[k];
                @(posedge clk);
                while (!s_ready) @(posedge clk);
                predictor.take_byte(sprite_bytes[k]);
                k++;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_valid <= 1'b0;

        // drain, then allow for anything still in flight
        while (predictor.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predictor.errors == 0) begin
            $display("tb_packed_sprite_to_span_words_top: PASS");
        end else begin
            $display("tb_packed_sprite_to_span_words_top: FAIL");
        end
        $finish;
    end

    // Sink side: check every accepted beat, stall in changing patterns
    initial begin : sink
        t_sink_mode mode;
        int         mode_left;
        bit         held;
        mode      = SINK_OPEN;
        mode_left = 0;
        held      = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (m_valid && m_ready) begin
                predictor.match_word('{word: m_data, last: m_last, bad: m_user});
            end
            if (!held && predictor.bytes_in >= HOLD_AFTER) begin
                // one long stall so the block backs up into its input
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_TOGGLE: m_ready <= ~m_ready;
                    SINK_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    default:     m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Run limit
    initial begin
        #(RUN_LIMIT);
        $display("tb_packed_sprite_to_span_words_top: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/pssw_pkg.sv
hdl/packed_sprite_to_span_words_top.sv
hdl/pssw_checker.sv
bench/tb_packed_sprite_to_span_words_top.sv
